>>> src/sbpdt_pkg.sv
// ----------------------------------------------------------------------------
// sbpdt_pkg
// Shared sizes, op codes and search result type for the slot buffer.
// ----------------------------------------------------------------------------
package sbpdt_pkg;

  localparam int SLOTS    = 16;
  localparam int TAG_BITS = 16;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Fixed field widths on the ports
  localparam int OP_FW   = 2;
  localparam int SLOT_FW = 4;
  localparam int TAG_FW  = 16;
  localparam int CNT_FW  = 5;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef enum logic [OP_FW-1:0] {
    OP_PLACE    = 2'd0,
    OP_DISPLACE = 2'd1,
    OP_TAKE     = 2'd2
  } op_t;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef struct packed {
    logic  place_ok;
    slot_t place_slot;
    logic  disp_ok;
    slot_t disp_slot;
    logic  take_ok;
    slot_t take_slot;
    logic  prev_ok;
    slot_t prev_slot;
  } search_t;

endpackage

>>> src/sbpdt_tag_ram.sv
// ----------------------------------------------------------------------------
// sbpdt_tag_ram
// Simple dual-port synchronous RAM, registered read that holds when idle.
// ----------------------------------------------------------------------------
module sbpdt_tag_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sbpdt_search.sv
// ----------------------------------------------------------------------------
// sbpdt_search
// Priority searches over the occupancy vector for place, displace and take.
// ----------------------------------------------------------------------------
module sbpdt_search (
  input  logic [sbpdt_pkg::SLOTS-1:0] occ,
  input  sbpdt_pkg::slot_t            place_ptr,
  input  sbpdt_pkg::slot_t            sel_ptr,
  output sbpdt_pkg::search_t          res
);
  import sbpdt_pkg::*;

  always_comb begin
    int idx;
    logic [SLOTS-1:0] occ_left;
    res = '0;
    idx = 0;

    // lowest free slot
    for (int k = 0; k < SLOTS; k++) begin
      if (!res.place_ok && !occ[k]) begin
        res.place_ok   = 1'b1;
        res.place_slot = slot_t'(k);
      end
    end

    // downward from the place pointer, with wrap
    for (int k = 0; k < SLOTS; k++) begin
      idx = int'(place_ptr) + SLOTS - k;
      if (idx >= SLOTS) idx = idx - SLOTS;
      if (!res.disp_ok && occ[slot_t'(idx)]) begin
        res.disp_ok   = 1'b1;
        res.disp_slot = slot_t'(idx);
      end
    end

    // upward from the select pointer, with wrap
    for (int k = 0; k < SLOTS; k++) begin
      idx = int'(sel_ptr) + k;
      if (idx >= SLOTS) idx = idx - SLOTS;
      if (!res.take_ok && occ[slot_t'(idx)]) begin
        res.take_ok   = 1'b1;
        res.take_slot = slot_t'(idx);
      end
    end

    // nearest occupied slot below the taken one, once it is cleared
    occ_left = occ;
    occ_left[res.take_slot] = 1'b0;
    for (int k = 1; k < SLOTS; k++) begin
      idx = int'(res.take_slot) + SLOTS - k;
      if (idx >= SLOTS) idx = idx - SLOTS;
      if (!res.prev_ok && occ_left[slot_t'(idx)]) begin
        res.prev_ok   = 1'b1;
        res.prev_slot = slot_t'(idx);
      end
    end
  end

endmodule

>>> src/slot_buffer_place_displace_take_unit.sv
// ----------------------------------------------------------------------------
// slot_buffer_place_displace_take_unit
// Slot buffer of request tags with place, displace and take requests.
// ----------------------------------------------------------------------------
// A request goes through search and tag RAM access into the pending register,
//   then the result register, and waits longer only while the result side stalls.
// Throughput: one request per cycle while results are taken; the tag RAM
//   read is the one stage a request spends before its result is formed.
// Reset (synchronous, rst_n low): buffer empty, count and both pointers zero,
//   no result pending. Tag RAM contents are not cleared.
// ----------------------------------------------------------------------------
module slot_buffer_place_displace_take_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbpdt_pkg::OP_FW-1:0]     in_op,
  input  logic [sbpdt_pkg::TAG_FW-1:0]    in_request_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [sbpdt_pkg::SLOT_FW-1:0]   out_slot,
  output logic [sbpdt_pkg::TAG_FW-1:0]    out_out_tag,
  output logic [sbpdt_pkg::CNT_FW-1:0]    out_count
);
  import sbpdt_pkg::*;

  logic [SLOTS-1:0] occ_r, occ_nxt;
  cnt_t             cnt_r, cnt_nxt;
  slot_t            pp_r, pp_nxt;
  slot_t            sp_r, sp_nxt;

  logic             p_valid_r;
  logic             p_status_r, p_status_nxt;
  slot_t            p_slot_r, p_slot_nxt;
  cnt_t             p_cnt_r;
  logic             p_from_ram_r, p_from_ram_nxt;
  logic [TAG_FW-1:0] p_tag_r, p_tag_nxt;

  logic             in_acc, p_move;
  logic             ram_we, ram_re;
  slot_t            ram_raddr;
  tag_t             ram_rdata;
  search_t          srch;

  assign p_move   = p_valid_r && (!out_valid || !out_stall);
  assign in_stall = p_valid_r && !p_move;
  assign in_acc   = in_valid && !in_stall;

  sbpdt_search u_search (
    .occ       (occ_r),
    .place_ptr (pp_r),
    .sel_ptr   (sp_r),
    .res       (srch)
  );

  sbpdt_tag_ram #(
    .DEPTH (SLOTS),
    .WIDTH (TAG_BITS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (srch.place_slot),
    .wdata (tag_t'(in_request_tag)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    occ_nxt        = occ_r;
    cnt_nxt        = cnt_r;
    pp_nxt         = pp_r;
    sp_nxt         = sp_r;
    p_status_nxt   = ST_REFUSED;
    p_slot_nxt     = '0;
    p_from_ram_nxt = 1'b0;
    p_tag_nxt      = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = srch.disp_slot;

    if (in_acc) begin
      case (in_op)
        OP_PLACE: begin
          if (srch.place_ok) begin
            occ_nxt[srch.place_slot] = 1'b1;
            cnt_nxt      = cnt_r + cnt_t'(1);
            pp_nxt       = srch.place_slot;
            ram_we       = 1'b1;
            p_status_nxt = ST_DONE;
            p_slot_nxt   = srch.place_slot;
            p_tag_nxt    = TAG_FW'(tag_t'(in_request_tag));
          end
        end
        OP_DISPLACE: begin
          if (srch.disp_ok) begin
            occ_nxt[srch.disp_slot] = 1'b0;
            cnt_nxt        = cnt_r - cnt_t'(1);
            pp_nxt         = (srch.disp_slot == '0) ? slot_t'(SLOTS - 1)
                                                    : srch.disp_slot - slot_t'(1);
            ram_re         = 1'b1;
            p_status_nxt   = ST_DONE;
            p_slot_nxt     = srch.disp_slot;
            p_from_ram_nxt = 1'b1;
          end
        end
        OP_TAKE: begin
          if (srch.take_ok) begin
            occ_nxt[srch.take_slot] = 1'b0;
            cnt_nxt        = cnt_r - cnt_t'(1);
            sp_nxt         = (srch.take_slot == slot_t'(SLOTS - 1)) ? '0
                                                    : srch.take_slot + slot_t'(1);
            // if the taken slot is the place pointer's, it follows to the nearest occupied slot below
            if (srch.take_slot == pp_r && srch.prev_ok) begin
              pp_nxt = srch.prev_slot;
            end
            ram_re         = 1'b1;
            ram_raddr      = srch.take_slot;
            p_status_nxt   = ST_DONE;
            p_slot_nxt     = srch.take_slot;
            p_from_ram_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      cnt_r     <= '0;
      pp_r      <= '0;
      sp_r      <= '0;
      p_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      cnt_r     <= cnt_nxt;
      pp_r      <= pp_nxt;
      sp_r      <= sp_nxt;
      p_valid_r <= in_acc || (p_valid_r && !p_move);
      out_valid <= p_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_status_r   <= p_status_nxt;
      p_slot_r     <= p_slot_nxt;
      p_cnt_r      <= cnt_nxt;
      p_from_ram_r <= p_from_ram_nxt;
      p_tag_r      <= p_tag_nxt;
    end
    if (p_move) begin
      out_status  <= p_status_r;
      out_slot    <= SLOT_FW'(p_slot_r);
      out_count   <= CNT_FW'(p_cnt_r);
      out_out_tag <= p_from_ram_r ? TAG_FW'(ram_rdata) : p_tag_r;
    end
  end

endmodule

>>> src/sbpdt_checker.sv
// ----------------------------------------------------------------------------
// sbpdt_checker
// Port-level checks on the slot buffer's result channel.
// ----------------------------------------------------------------------------
module sbpdt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_status,
  input logic [sbpdt_pkg::SLOT_FW-1:0] out_slot,
  input logic [sbpdt_pkg::TAG_FW-1:0]  out_out_tag,
  input logic [sbpdt_pkg::CNT_FW-1:0]  out_count
);
  import sbpdt_pkg::*;

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_out_tag) && $stable(out_count))
    else $error("stalled result changed");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_REFUSED |-> out_slot == '0 && out_out_tag == '0)
    else $error("refused request carries slot or tag");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_count) <= SLOTS)
    else $error("count beyond buffer size");

endmodule

bind slot_buffer_place_displace_take_unit sbpdt_checker u_sbpdt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_slot    (out_slot),
  .out_out_tag (out_out_tag),
  .out_count   (out_count)
);
